### sv/sha1_message_digest_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Shared same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SHA1MD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha1md: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SHA1MD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha1md: next-cycle check failed");

`endif

### sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and helper functions shared by the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 16;
   localparam int BLOCK_W   = NUM_WORDS * WORD_W;
   localparam int CNT_W     = 64;
   localparam int NUM_CHAIN = 5;
   localparam int ROUNDS    = 80;
   localparam int STAGE_LEN = 20;
   localparam int POS_W     = 6;
   localparam int ROUND_W   = 7;
   localparam int IDX_W     = 3;

   localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
   localparam logic [POS_W-1:0]   LEN_POS    = 6'd56;
   localparam logic [POS_W-1:0]   LEN_BYTES  = 6'(CNT_W / BYTE_W);
   localparam logic [POS_W-1:0]   POS_LAST   = '1;
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
   localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(NUM_CHAIN - 1);
   localparam logic [CNT_W-1:0]   BITS_PER_BYTE = CNT_W'(BYTE_W);

   localparam logic [NUM_CHAIN-1:0][WORD_W-1:0] IV_VALUES = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO
   } byte_src_type;

   typedef enum logic [1:0] {
      STAGE_CH,
      STAGE_PAR1,
      STAGE_MAJ,
      STAGE_PAR2
   } stage_type;

   typedef struct packed {
      logic         shift_byte;
      byte_src_type src;
      logic         count_bits;
      logic         load_len;
      logic         load_vars;
      logic         do_round;
      logic         fold;
      logic         emit_next;
      logic         reinit;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_len;
      logic round_last;
      logic word_last;
   } dp_status_type;

   function automatic stage_type round_stage(input logic [ROUND_W-1:0] t);
      stage_type s;
      if (t < ROUND_W'(STAGE_LEN))          s = STAGE_CH;
      else if (t < ROUND_W'(2 * STAGE_LEN)) s = STAGE_PAR1;
      else if (t < ROUND_W'(3 * STAGE_LEN)) s = STAGE_MAJ;
      else                                  s = STAGE_PAR2;
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input stage_type s);
      logic [WORD_W-1:0] k;
      unique case (s)
         STAGE_CH:   k = 32'h5A827999;
         STAGE_PAR1: k = 32'h6ED9EBA1;
         STAGE_MAJ:  k = 32'h8F1BBCDC;
         STAGE_PAR2: k = 32'hCA62C1D6;
         default:    k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

### sv/sha1md_if.sv
// ----------------------------------------------------------------------------
// sha1md channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1md_req_if import sha1md_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_present;
   logic              final_item;

   modport source (output valid, output data_byte, output byte_present,
                   output final_item, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input final_item, output ready);
endinterface

interface sha1md_rsp_if import sha1md_pkg::*;;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [IDX_W-1:0]  word_index;
   logic              last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

### sv/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: byte intake, padding, round loop, fold and digest output.
// ----------------------------------------------------------------------------
module sha1md_ctrl import sha1md_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_byte_present,
   input  logic          req_final_item,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output logic          req_ready,
   output logic          rsp_valid,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;        // final item seen, padding pending
   logic      sent80_ff, sent80_in;  // marker byte already inserted
   logic      len_ff, len_in;        // length block loaded

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fin_ff    <= 1'b0;
         sent80_ff <= 1'b0;
         len_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fin_ff    <= fin_in;
         sent80_ff <= sent80_in;
         len_ff    <= len_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present && status.pos_last) state_in = ST_ROUND;
               else if (req_final_item)                 state_in = ST_PAD;
            end
         end
         ST_ROUND: begin
            if (status.round_last) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (len_ff)      state_in = ST_EMIT;
            else if (fin_ff) state_in = ST_PAD;
            else             state_in = ST_IDLE;
         end
         ST_PAD: begin
            if (!sent80_ff) begin
               if (status.pos_last) state_in = ST_ROUND;
            end else if (status.pos_len || status.pos_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.word_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      cmd       = '0;
      cmd.src   = SRC_DATA;
      fin_in    = fin_ff;
      sent80_in = sent80_ff;
      len_in    = len_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fin_in = req_final_item;
               if (req_byte_present) begin
                  cmd.shift_byte = 1'b1;
                  cmd.count_bits = 1'b1;
                  cmd.load_vars  = status.pos_last;
               end
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_PAD: begin
            if (!sent80_ff) begin
               cmd.shift_byte = 1'b1;
               cmd.src        = SRC_PAD;
               cmd.load_vars  = status.pos_last;
               sent80_in      = 1'b1;
            end else if (status.pos_len) begin
               cmd.load_len  = 1'b1;
               cmd.load_vars = 1'b1;
               len_in        = 1'b1;
            end else begin
               cmd.shift_byte = 1'b1;
               cmd.src        = SRC_ZERO;
               cmd.load_vars  = status.pos_last;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.word_last) begin
                  cmd.reinit = 1'b1;
                  fin_in     = 1'b0;
                  sent80_in  = 1'b0;
                  len_in     = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

### sv/sha1md_datapath.sv
// ----------------------------------------------------------------------------
// sha1md_datapath
// Block shift line, message schedule, round unit, chaining values, counters.
// ----------------------------------------------------------------------------
module sha1md_datapath import sha1md_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [BYTE_W-1:0]   data_byte,
   output dp_status_type       status,
   output logic [WORD_W-1:0]   digest_word,
   output logic [IDX_W-1:0]    word_index,
   output logic                last_word
);

   // block words, word 0 in the top bits; bytes and schedule words shift in low
   logic [BLOCK_W-1:0]                window_ff, window_in;
   logic [POS_W-1:0]                  pos_ff;
   logic [CNT_W-1:0]                  bits_ff;
   logic [NUM_CHAIN-1:0][WORD_W-1:0]  chain_ff;
   logic [WORD_W-1:0]                 a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [ROUND_W-1:0]                round_ff;
   logic [IDX_W-1:0]                  index_ff;

   logic [BYTE_W-1:0] byte_val;
   logic [WORD_W-1:0] w0, w2, w8, w13, w_mix, w_next;
   logic [WORD_W-1:0] f_val, temp;
   stage_type         stage;

   assign w0  = window_ff[BLOCK_W - 1              -: WORD_W];
   assign w2  = window_ff[BLOCK_W - 1 - 2 * WORD_W  -: WORD_W];
   assign w8  = window_ff[BLOCK_W - 1 - 8 * WORD_W  -: WORD_W];
   assign w13 = window_ff[BLOCK_W - 1 - 13 * WORD_W -: WORD_W];
   assign w_mix  = w13 ^ w8 ^ w2 ^ w0;
   assign w_next = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

   assign stage = round_stage(round_ff);

   always_comb begin
      unique case (stage)
         STAGE_CH:   f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         STAGE_MAJ:  f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:    f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign temp = {a_ff[WORD_W-6:0], a_ff[WORD_W-1:WORD_W-5]} + f_val + e_ff
                 + round_k(stage) + w0;

   always_comb begin
      unique case (cmd.src)
         SRC_DATA: byte_val = data_byte;
         SRC_PAD:  byte_val = PAD_BYTE;
         default:  byte_val = '0;
      endcase
   end

   always_comb begin
      priority if (cmd.shift_byte) window_in = {window_ff[BLOCK_W-BYTE_W-1:0], byte_val};
      else if (cmd.load_len)       window_in = {window_ff[BLOCK_W-CNT_W-1:0], bits_ff};
      else if (cmd.do_round)       window_in = {window_ff[BLOCK_W-WORD_W-1:0], w_next};
      else                         window_in = window_ff;
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   // round variables
   always_ff @(posedge clock) begin
      if (cmd.load_vars) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.do_round) begin
         a_ff <= temp;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[WORD_W-1:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else if (cmd.load_vars) begin
         round_ff <= '0;
      end else if (cmd.do_round) begin
         round_ff <= round_ff + ROUND_W'(1);
      end
   end

   // chaining values, bit count, byte slot, output index
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         chain_ff <= IV_VALUES;
         bits_ff  <= '0;
         pos_ff   <= '0;
         index_ff <= '0;
      end else begin
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
         end
         if (cmd.count_bits) bits_ff <= bits_ff + BITS_PER_BYTE;
         if (cmd.shift_byte)    pos_ff <= pos_ff + POS_W'(1);
         else if (cmd.load_len) pos_ff <= pos_ff + LEN_BYTES;
         if (cmd.emit_next) index_ff <= index_ff + IDX_W'(1);
      end
   end

   assign status.pos_last   = (pos_ff == POS_LAST);
   assign status.pos_len    = (pos_ff == LEN_POS);
   assign status.round_last = (round_ff == LAST_ROUND);
   assign status.word_last  = (index_ff == LAST_INDEX);

   assign digest_word = chain_ff[index_ff];
   assign word_index  = index_ff;
   assign last_word   = status.word_last;

endmodule

### sv/sha1_message_digest_top.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 hash over a byte stream, digest out as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per handshake: data_byte, byte_present and
//   final_item. An item without a byte and without final_item is a no-op.
//   rsp_if returns the digest after a final item as five words, index 0
//   (most significant) first, last_word set on index 4.
// Sequence:
//   A byte item is accepted whenever the block is idle. The item that completes
//   a 64-byte block starts the rounds on the single round unit and then a fold;
//   meanwhile no item is taken. After the final item the block shifts in the
//   0x80 marker and zero pad bytes up to the length field, loads the 64-bit
//   length, runs rounds and fold for each padded block (one or two blocks),
//   then returns the five words.
// Reset clears the sequencer, bit count, byte slot and loads the initial
//   chaining values; req_if is ready in the first cycle after reset.
// Stall: while rsp_if is not ready the current word holds; no further item
//   is taken until the fifth word is delivered, after which the block
//   returns to its initial state for the next message.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_top_macros.svh"

module sha1_message_digest_top import sha1md_pkg::*; (
   input logic          clock,
   input logic          reset,
   sha1md_req_if.sink   req_if,
   sha1md_rsp_if.source rsp_if
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sha1md_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_byte_present (req_if.byte_present),
      .req_final_item   (req_if.final_item),
      .rsp_ready        (rsp_if.ready),
      .status           (status),
      .req_ready        (req_if.ready),
      .rsp_valid        (rsp_if.valid),
      .cmd              (cmd)
   );

   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_if.data_byte),
      .status      (status),
      .digest_word (rsp_if.digest_word),
      .word_index  (rsp_if.word_index),
      .last_word   (rsp_if.last_word)
   );

   // output phase and intake never overlap
   `SHA1MD_ASSERT_SAME(a_no_overlap, clock, reset, rsp_if.valid, !req_if.ready)

   // a final item always leads to padding, so intake stops
   `SHA1MD_ASSERT_NEXT(a_final_blocks, clock, reset,
      req_if.valid && req_if.ready && req_if.final_item, !req_if.ready)

   // after the fifth word the block is ready for a new message
   `SHA1MD_ASSERT_NEXT(a_back_to_idle, clock, reset,
      rsp_if.valid && rsp_if.ready && rsp_if.last_word, req_if.ready && !rsp_if.valid)

endmodule

### dv/tb_sha1_message_digest_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_top
// Streams messages one byte per item into the SHA-1 block and checks every
// digest word against an in-bench SHA-1 computation, under random stalls on
// both channels, with padding boundaries, multi-block and empty messages.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_top;
   import sha1md_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 480;
   localparam int unsigned STALL_LIMIT  = 20000;
   localparam int unsigned TAIL_CYCLES  = 300;
   localparam int unsigned MAX_REPORTS  = 10;

   localparam logic [WORD_W-1:0] K_CH   = 32'h5A827999;
   localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K_MAJ  = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K_PAR2 = 32'hCA62C1D6;

   typedef struct {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_present;
      logic              final_item;
      bit                drain_first;   // hold off until all digests are out
      int unsigned       phase;
   } msg_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [IDX_W-1:0]  word_index;
      logic              last_word;
   } digest_word_type;

   logic clock = 1'b0;
   logic reset;

   sha1md_req_if req_if ();
   sha1md_rsp_if rsp_if ();

   sha1_message_digest_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   msg_item_type    pending [$];
   digest_word_type digest_q [$];
   msg_item_type    cur_item;
   int unsigned  items_queued   = 0;
   int unsigned  items_accepted = 0;
   int unsigned  error_count    = 0;
   int unsigned  stall_cycles   = 0;
   int unsigned  link_phase     = 0;

   // predictor state
   logic [WORD_W-1:0] blk_w   [NUM_WORDS];
   logic [WORD_W-1:0] chain_h [NUM_CHAIN];
   logic [CNT_W-1:0]  bit_count;
   logic [POS_W-1:0]  fill_pos;

   function automatic void digest_reset();
      for (int i = 0; i < NUM_WORDS; i++) blk_w[i] = '0;
      for (int i = 0; i < NUM_CHAIN; i++) chain_h[i] = IV_VALUES[i];
      bit_count = '0;
      fill_pos  = '0;
   endfunction

   function automatic void sha1_compress();
      logic [WORD_W-1:0] w [ROUNDS];
      logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < NUM_WORDS; i++) w[i] = blk_w[i];
      for (int i = NUM_WORDS; i < ROUNDS; i++) begin
         t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {t[30:0], t[31]};
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int i = 0; i < ROUNDS; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_PAR1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PAR2;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void pack_byte(input logic [BYTE_W-1:0] b);
      int sh;
      sh = 8 * (3 - int'(fill_pos[1:0]));
      blk_w[fill_pos[5:2]][sh +: 8] = b;
      fill_pos = fill_pos + POS_W'(1);
      if (fill_pos == '0) sha1_compress();
   endfunction

   function automatic void predict_digest(input msg_item_type it);
      digest_word_type r;
      if (it.byte_present) begin
         pack_byte(it.data_byte);
         bit_count += BITS_PER_BYTE;
      end
      if (it.final_item) begin
         pack_byte(PAD_BYTE);
         while (fill_pos != LEN_POS) pack_byte('0);
         blk_w[14] = bit_count[63:32];
         blk_w[15] = bit_count[31:0];
         sha1_compress();
         for (int i = 0; i < NUM_CHAIN; i++) begin
            r.digest_word = chain_h[i];
            r.word_index  = IDX_W'(i);
            r.last_word   = (IDX_W'(i) == LAST_INDEX);
            digest_q.push_back(r);
         end
         digest_reset();
      end
   endfunction

   function automatic void queue_item(input logic [BYTE_W-1:0] d, input logic present,
                                      input logic fin, input bit drain,
                                      input int unsigned ph);
      msg_item_type it;
      it.data_byte    = d;
      it.byte_present = present;
      it.final_item   = fin;
      it.drain_first  = drain;
      it.phase        = ph;
      pending.push_back(it);
      items_queued++;
   endfunction

   // Returns the number of items that carry a byte or end the message.
   function automatic int unsigned queue_message(input int unsigned nbytes,
                                                 input bit last_on_final,
                                                 input int unsigned noise_pct,
                                                 input bit drain,
                                                 input int unsigned ph);
      int unsigned plain;
      bit          hold;
      hold  = drain;
      plain = last_on_final ? nbytes - 1 : nbytes;
      for (int unsigned i = 0; i < plain; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            queue_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b0, hold, ph);
            hold = 1'b0;
         end
         queue_item(BYTE_W'($urandom_range(255)), 1'b1, 1'b0, hold, ph);
         hold = 1'b0;
      end
      queue_item(BYTE_W'($urandom_range(255)), last_on_final, 1'b1, hold, ph);
      return plain + 1;
   endfunction

   function automatic int unsigned sender_idle_pct(input int unsigned ph);
      case (ph)
         0:       return 13;
         1:       return 59;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_idle_pct(input int unsigned ph);
      case (ph)
         0:       return 59;
         1:       return 13;
         default: return 0;
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input digest_word_type want,
                                         input digest_word_type got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s: expected word=%h idx=%0d last=%b, got word=%h idx=%0d last=%b",
                  $realtime, what, want.digest_word, want.word_index, want.last_word,
                  got.digest_word, got.word_index, got.last_word);
   endfunction

   // driver
   always @(posedge clock) begin
      bit launch;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_digest(cur_item);
            items_accepted++;
            link_phase <= cur_item.phase;
         end
         if (!req_if.valid || req_if.ready) begin
            launch = 1'b0;
            if (pending.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(pending[0].phase) &&
                (!pending[0].drain_first || digest_q.size() == 0))
               launch = 1'b1;
            if (launch) begin
               cur_item = pending.pop_front();
               req_if.valid        <= 1'b1;
               req_if.data_byte    <= cur_item.data_byte;
               req_if.byte_present <= cur_item.byte_present;
               req_if.final_item   <= cur_item.final_item;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      digest_word_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.digest_word = rsp_if.digest_word;
            got.word_index  = rsp_if.word_index;
            got.last_word   = rsp_if.last_word;
            if (digest_q.size() == 0) begin
               want = '0;
               note_mismatch("unexpected digest item", want, got);
            end else begin
               want = digest_q.pop_front();
               if (got !== want) note_mismatch("digest mismatch", want, got);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct(link_phase));
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int unsigned counted;
      int unsigned len;
      int unsigned ph;
      int unsigned dummy;
      bit          on_final;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.data_byte    = '0;
      req_if.byte_present = 1'b0;
      req_if.final_item   = 1'b0;
      rsp_if.ready        = 1'b0;
      digest_reset();

      // empty message
      queue_item(8'h00, 1'b0, 1'b1, 1'b0, 0);
      // "abc", last byte on the final item
      queue_item(8'h61, 1'b1, 1'b0, 1'b0, 0);
      queue_item(8'h62, 1'b1, 1'b0, 1'b0, 0);
      queue_item(8'h63, 1'b1, 1'b1, 1'b0, 0);
      // lone no-op ahead of a byteless final: still the empty digest
      queue_item(8'hFF, 1'b0, 1'b0, 1'b0, 0);
      queue_item(8'hFF, 1'b0, 1'b1, 1'b0, 0);
      // extreme byte values
      queue_item(8'hFF, 1'b1, 1'b1, 1'b0, 0);
      queue_item(8'h00, 1'b1, 1'b0, 1'b0, 0);
      queue_item(8'hA5, 1'b0, 1'b1, 1'b0, 0);
      // bytes, a no-op in between, padding after the bytes seen so far;
      // first waits until every earlier digest word is out
      queue_item(8'h55, 1'b1, 1'b0, 1'b1, 0);
      queue_item(8'h3C, 1'b0, 1'b0, 1'b0, 0);
      queue_item(8'hAA, 1'b1, 1'b0, 1'b0, 0);
      queue_item(8'h00, 1'b0, 1'b1, 1'b0, 0);
      // one byte with final set, then immediately a byteless final
      queue_item(8'h80, 1'b1, 1'b1, 1'b0, 0);
      queue_item(8'h7F, 1'b0, 1'b1, 1'b0, 0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         ph = counted * 3 / RANDOM_ITEMS;
         case ($urandom_range(9))
            0, 1:    len = $urandom_range(55, 65);    // one vs two pad blocks
            2:       len = $urandom_range(110, 130);  // chained blocks
            default: len = $urandom_range(0, 40);
         endcase
         on_final = (len != 0) && ($urandom_range(1) == 1);
         dummy = queue_message(len, on_final, ($urandom_range(1) == 1) ? 12 : 0,
                               ($urandom_range(7) == 0), ph);
         counted += dummy;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (items_accepted != items_queued || digest_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
